FILE: hdl/assert_macros.svh
// Assertion macros used by the checker file, ppsf_checker.sv.
// No dependencies; take in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent assertion that also runs during reset.
`define ASSERT_CLK_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

FILE: hdl/ppsf_pkg.sv
// Package for the printer-port sample queue: payload types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppsf_pkg;

   localparam int PPSF_QUEUE_DEPTH = 64;
   localparam int PPSF_BUSY_MARGIN = 16;

   localparam logic [15:0] BASE_RESET = 16'd888;

   // transaction codes
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_POP   = 2'd2;

   // register offsets; OFS_NONE marks an address outside the block
   typedef enum logic [1:0] {
      OFS_DATA    = 2'd0,
      OFS_STATUS  = 2'd1,
      OFS_CONTROL = 2'd2,
      OFS_NONE    = 2'd3
   } offset_type;

   localparam logic [7:0] STATUS_IDLE = 8'hDF;
   localparam logic [7:0] BUSY_MASK   = 8'h80;
   localparam logic [7:0] STROBE_MASK = 8'h01;
   localparam logic [7:0] OPEN_BUS    = 8'hFF;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] port_address;
      logic [7:0]  write_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_value;
      logic       sample_valid;
      logic [7:0] sample_value;
   } rsp_type;

   typedef logic [15:0] csr_type;

endpackage

`default_nettype wire

FILE: hdl/ppsf_chan_if.sv
// Valid/ready channel interface, payload type set by parameter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface ppsf_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hdl/ppsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/parallel_port_sample_fifo.sv
// Printer-port register block with an audio sample queue; uses ppsf_pkg,
// ppsf_chan_if and ppsf_ram. A request passes stage s1, then the response register.
// One transaction per cycle unless the response stalls; a pop reads the queue RAM
// in the accept cycle, the data lands the next cycle. Synchronous reset clears the
// registers and queue pointers; queue contents stay undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module parallel_port_sample_fifo
   import ppsf_pkg::*;
#(
   parameter int QUEUE_DEPTH = PPSF_QUEUE_DEPTH,
   parameter int BUSY_MARGIN = PPSF_BUSY_MARGIN
) (
   input wire logic   clock,
   input wire logic   reset,
   ppsf_chan_if.sink   req_chan,
   ppsf_chan_if.source rsp_chan,
   ppsf_chan_if.sink   csr_chan
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   logic [15:0]      base_ff, base_in;
   logic [7:0]       latch_ff, latch_in;
   logic [7:0]       ctrl_ff, ctrl_in;
   logic             audio_ff, audio_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pop_ff, s1_pop_in;
   logic [7:0]       s1_read_ff, s1_read_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   req_type          req;
   logic             accept;
   logic             out_free;
   logic             s1_free;
   logic [16:0]      diff;
   offset_type       offset;
   logic [PTR_W-1:0] head_next;
   logic [PTR_W-1:0] tail_next;
   logic [CNT_W-1:0] count;
   logic             busy;
   logic [7:0]       status;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [7:0]       ram_rd_data;

   assign req      = req_chan.payload;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_free  = !s1_valid_ff || out_free;
   assign req_chan.ready = s1_free && !reset;
   assign accept   = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = !reset;

   // address decode, no wrap-around below the base
   always_comb begin
      diff = {1'b0, req.port_address} - {1'b0, base_ff};
      if (!diff[16] && (diff[15:2] == '0) && (diff[1:0] != OFS_NONE)) begin
         offset = offset_type'(diff[1:0]);
      end else begin
         offset = OFS_NONE;
      end
   end

   assign head_next = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
   assign tail_next = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);

   always_comb begin
      if (tail_ff >= head_ff) begin
         count = {1'b0, tail_ff} - {1'b0, head_ff};
      end else begin
         count = {1'b0, tail_ff} + CNT_W'(QUEUE_DEPTH) - {1'b0, head_ff};
      end
   end

   assign busy   = audio_ff && (count > CNT_W'(QUEUE_DEPTH - BUSY_MARGIN));
   assign status = busy ? (STATUS_IDLE & ~BUSY_MASK) : STATUS_IDLE;

   always_comb begin
      base_in    = base_ff;
      latch_in   = latch_ff;
      ctrl_in    = ctrl_ff;
      audio_in   = audio_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      s1_pop_in  = s1_pop_ff;
      s1_read_in = s1_read_ff;
      ram_wr_en  = 1'b0;
      ram_rd_en  = 1'b0;

      if (csr_chan.valid && csr_chan.ready) begin
         base_in = csr_chan.payload;
      end

      if (accept) begin
         s1_pop_in  = 1'b0;
         s1_read_in = '0;
         unique case (req.mode)
            MODE_READ: begin
               unique case (offset)
                  OFS_DATA:    s1_read_in = latch_ff;
                  OFS_STATUS:  s1_read_in = status;
                  OFS_CONTROL: s1_read_in = ctrl_ff;
                  default:     s1_read_in = OPEN_BUS;
               endcase
            end
            MODE_WRITE: begin
               unique case (offset)
                  OFS_DATA: latch_in = req.write_value;
                  OFS_CONTROL: begin
                     ctrl_in = req.write_value;
                     // strobe rising edge queues the latch; full queue drops it
                     if (((req.write_value & STROBE_MASK) != '0) &&
                         ((ctrl_ff & STROBE_MASK) == '0)) begin
                        audio_in = 1'b1;
                        if (tail_next != head_ff) begin
                           ram_wr_en = 1'b1;
                           tail_in   = tail_next;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            MODE_POP: begin
               if (head_ff != tail_ff) begin
                  ram_rd_en = 1'b1;
                  s1_pop_in = 1'b1;
                  head_in   = head_next;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_valid_ff && out_free) begin
         s1_valid_in             = 1'b0;
         rsp_valid_in            = 1'b1;
         rsp_in.read_value   = s1_read_ff;
         rsp_in.sample_valid = s1_pop_ff;
         rsp_in.sample_value = s1_pop_ff ? ram_rd_data : '0;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         latch_ff     <= '0;
         ctrl_ff      <= '0;
         audio_ff     <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         latch_ff     <= latch_in;
         ctrl_ff      <= ctrl_in;
         audio_ff     <= audio_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pop_ff  <= s1_pop_in;
      s1_read_ff <= s1_read_in;
      rsp_ff     <= rsp_in;
   end

   ppsf_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (tail_ff),
      .wr_data (latch_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (head_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/ppsf_checker.sv
// Port-level checker for parallel_port_sample_fifo, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ppsf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_value,
   input wire logic       rsp_sample_valid,
   input wire logic [7:0] rsp_sample_value
);

   // stalled response keeps valid and payload
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_sample_valid) && $stable(rsp_sample_value))

   // no response right after reset
   `ASSERT_CLK_NORST(a_reset_clears, clock, $past(reset) |-> !rsp_valid)

   // a fresh response follows an accepted request through the s1 stage
   `ASSERT_CLK(a_rsp_from_req, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))

endmodule

bind parallel_port_sample_fifo ppsf_checker u_ppsf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_read_value   (rsp_chan.payload.read_value),
   .rsp_sample_valid (rsp_chan.payload.sample_valid),
   .rsp_sample_value (rsp_chan.payload.sample_value)
);

`default_nettype wire

FILE: bench/parallel_port_sample_fifo_tb.sv
// Testbench for parallel_port_sample_fifo: drives bus reads, writes and pops, predicts each
// response with a scoreboard model of the registers and sample queue.
// Depends on ppsf_pkg, ppsf_chan_if and the RTL top level.
`timescale 1ns / 1ps

module parallel_port_sample_fifo_tb;
   import ppsf_pkg::*;

   localparam logic [1:0] MODE_SPARE = 2'd3;  // unused selector, must do nothing
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 10;
   localparam int PRESSURE_AT = 300;           // accepted requests before the long stall
   localparam int PRESSURE_CYCLES = 400;

   class port_queue_scoreboard;
      logic [15:0] base_address = BASE_RESET;
      logic [7:0]  data_latch = 8'h00;
      logic [7:0]  control_reg = 8'h00;
      logic        audio_on = 1'b0;
      int          head = 0;
      int          tail = 0;
      logic [7:0]  ring [PPSF_QUEUE_DEPTH];
      rsp_type     pending_replies[$];
      int          bad_replies = 0;

      function void set_base(logic [15:0] b);
         base_address = b;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function int fill_level();
         return (tail - head + PPSF_QUEUE_DEPTH) % PPSF_QUEUE_DEPTH;
      endfunction

      // no wrap-around: addresses below the base are outside the block
      function offset_type decode(logic [15:0] port);
         int diff;
         diff = int'(port) - int'(base_address);
         if (diff < 0 || diff > 2)
            return OFS_NONE;
         return offset_type'(diff);
      endfunction

      function void take_request(req_type r);
         rsp_type    want;
         offset_type ofs;
         logic       rising;
         want = '0;
         ofs = decode(r.port_address);
         case (r.mode)
            MODE_READ: begin
               case (ofs)
                  OFS_DATA: want.read_value = data_latch;
                  OFS_STATUS: begin
                     want.read_value = STATUS_IDLE;
                     if (audio_on && fill_level() > PPSF_QUEUE_DEPTH - PPSF_BUSY_MARGIN)
                        want.read_value = want.read_value & ~BUSY_MASK;
                  end
                  OFS_CONTROL: want.read_value = control_reg;
                  default: want.read_value = OPEN_BUS;
               endcase
            end
            MODE_WRITE: begin
               case (ofs)
                  OFS_DATA: data_latch = r.write_value;
                  OFS_CONTROL: begin
                     rising = ((r.write_value & STROBE_MASK) != 0) &&
                              ((control_reg & STROBE_MASK) == 0);
                     control_reg = r.write_value;
                     if (rising) begin
                        // one slot stays free; a strobe on a full queue drops the byte
                        if ((tail + 1) % PPSF_QUEUE_DEPTH != head) begin
                           ring[tail] = data_latch;
                           tail = (tail + 1) % PPSF_QUEUE_DEPTH;
                        end
                        audio_on = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_POP: begin
               if (head != tail) begin
                  want.sample_valid = 1'b1;
                  want.sample_value = ring[head];
                  head = (head + 1) % PPSF_QUEUE_DEPTH;
               end
            end
            default: ;
         endcase
         pending_replies.push_back(want);
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         bad_replies++;
         if (bad_replies <= REPORT_LIMIT)
            $display("%0t: %s: expected read %02h valid %0d sample %02h, got read %02h valid %0d sample %02h",
                     $time, what, want.read_value, want.sample_valid, want.sample_value,
                     got.read_value, got.sample_valid, got.sample_value);
      endfunction

      function void match_response(rsp_type got);
         rsp_type want;
         if (pending_replies.size() == 0) begin
            report("response with nothing outstanding", '0, got);
            return;
         end
         want = pending_replies.pop_front();
         if (got.read_value !== want.read_value || got.sample_valid !== want.sample_valid ||
             got.sample_value !== want.sample_value)
            report("response mismatch", want, got);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycles = 0;
   int   accepted_requests = 0;
   int   burst_left = 0;
   port_queue_scoreboard sb;

   ppsf_chan_if #(.payload_type(req_type)) req_if ();
   ppsf_chan_if #(.payload_type(rsp_type)) rsp_if ();
   ppsf_chan_if #(.payload_type(csr_type)) csr_if ();

   parallel_port_sample_fifo i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("parallel_port_sample_fifo_tb: errors");
         $finish;
      end
   end

   // address at a given offset from the current base, random when it falls off the map
   function automatic logic [15:0] port_at(int ofs);
      int p;
      p = int'(sb.base_address) + ofs;
      if (p < 0 || p > 65535)
         return 16'($urandom);
      return 16'(p);
   endfunction

   // bursts of random length, random gaps between them
   task automatic pace();
      int gap;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? 64 : $urandom_range(1, 16);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_request(logic [1:0] mode, logic [15:0] port, logic [7:0] value);
      req_type r;
      r.mode = mode;
      r.port_address = port;
      r.write_value = value;
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      sb.take_request(r);
      accepted_requests++;
      pace();
   endtask

   // only while idle: drain, let the pipeline settle, then write
   task automatic write_base(logic [15:0] b);
      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.payload <= b;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      sb.set_base(b);
   endtask

   task automatic run_phase(int budget, int push_w, int pop_w);
      int start;
      int pick;
      int n;
      start = accepted_requests;
      while (accepted_requests - start < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < push_w) begin
            // strobe sequence: optional latch load, control low, control high, optional status read
            if ($urandom_range(0, 2) != 0)
               send_request(MODE_WRITE, port_at(int'(OFS_DATA)), 8'($urandom));
            send_request(MODE_WRITE, port_at(int'(OFS_CONTROL)), {7'($urandom), 1'b0});
            send_request(MODE_WRITE, port_at(int'(OFS_CONTROL)), {7'($urandom), 1'b1});
            if ($urandom_range(0, 3) == 0)
               send_request(MODE_READ, port_at(int'(OFS_STATUS)), 8'($urandom));
         end else if (pick < push_w + pop_w) begin
            n = $urandom_range(1, 4);
            repeat (n) send_request(MODE_POP, 16'($urandom), 8'($urandom));
         end else if (pick < push_w + pop_w + 10) begin
            send_request(MODE_READ, port_at($urandom_range(0, 4) - 1), 8'($urandom));
         end else begin
            send_request(2'($urandom_range(0, 3)),
                         $urandom_range(0, 1) ? port_at($urandom_range(0, 6) - 2)
                                              : 16'($urandom),
                         8'($urandom));
         end
      end
   endtask

   // receiver: own stall pattern plus one long hold-off to back up the queue
   initial begin : response_side
      int         hold_left;
      int         pattern_left;
      logic [15:0] stall_mask;
      bit         pressure_done;
      hold_left = 0;
      pattern_left = 0;
      stall_mask = 16'hFFFF;
      pressure_done = 1'b0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.match_response(rsp_if.payload);
         if (!pressure_done && accepted_requests >= PRESSURE_AT) begin
            hold_left = PRESSURE_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(16, 96);
               stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            end
            pattern_left--;
            rsp_if.ready <= stall_mask[pattern_left % 16];
         end
      end
   end

   initial begin : request_side
      sb = new;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid <= 1'b0;
      csr_if.payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: decode edges, ignored writes, strobe edges, empty pop, spare mode
      send_request(MODE_READ, port_at(int'(OFS_DATA)), 8'h00);
      send_request(MODE_READ, port_at(int'(OFS_STATUS)), 8'h00);
      send_request(MODE_READ, port_at(int'(OFS_CONTROL)), 8'h00);
      send_request(MODE_READ, port_at(-1), 8'h00);
      send_request(MODE_READ, port_at(3), 8'h00);
      send_request(MODE_READ, 16'h0000, 8'hFF);
      send_request(MODE_READ, 16'hFFFF, 8'hFF);
      send_request(MODE_POP, 16'hFFFF, 8'hFF);
      send_request(MODE_WRITE, port_at(int'(OFS_STATUS)), 8'hFF);
      send_request(MODE_READ, port_at(int'(OFS_STATUS)), 8'h00);
      send_request(MODE_WRITE, port_at(-1), 8'hAA);
      send_request(MODE_WRITE, port_at(3), 8'h55);
      send_request(MODE_WRITE, port_at(int'(OFS_DATA)), 8'hFF);
      send_request(MODE_WRITE, port_at(int'(OFS_CONTROL)), 8'h01);
      send_request(MODE_READ, port_at(int'(OFS_STATUS)), 8'h00);
      send_request(MODE_WRITE, port_at(int'(OFS_CONTROL)), 8'hFF);   // no edge
      send_request(MODE_READ, port_at(int'(OFS_CONTROL)), 8'h00);
      send_request(MODE_WRITE, port_at(int'(OFS_CONTROL)), 8'hFE);
      send_request(MODE_WRITE, port_at(int'(OFS_DATA)), 8'h00);
      send_request(MODE_WRITE, port_at(int'(OFS_CONTROL)), 8'h01);
      send_request(MODE_POP, 16'h0000, 8'h00);
      send_request(MODE_POP, 16'h0000, 8'h00);
      send_request(MODE_POP, 16'h0000, 8'h00);
      send_request(MODE_SPARE, port_at(int'(OFS_DATA)), 8'h55);
      send_request(MODE_READ, port_at(int'(OFS_DATA)), 8'h00);

      // fill phases first so the queue reaches busy and full, then drain
      run_phase(110, 75, 5);
      write_base(16'h0000);
      run_phase(110, 75, 5);
      write_base(16'($urandom_range(3, 65533)));
      run_phase(110, 70, 10);
      write_base(16'hFFFF);
      run_phase(90, 10, 60);
      write_base(16'hFFFE);
      run_phase(90, 10, 60);
      write_base(BASE_RESET);
      run_phase(110, 35, 35);

      req_if.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.bad_replies == 0 && sb.pending() == 0)
         $display("parallel_port_sample_fifo_tb: clean");
      else
         $display("parallel_port_sample_fifo_tb: errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ppsf_pkg.sv
hdl/ppsf_chan_if.sv
hdl/ppsf_ram.sv
hdl/parallel_port_sample_fifo.sv
hdl/ppsf_checker.sv
bench/parallel_port_sample_fifo_tb.sv
